>>> sv/crr_pkg.sv
// ---------------------------------------------------------------------------
// crr_pkg: shared types and constants for contained read removal
// Holds default sizes, the controller state type and the command/status
// structures between controller and datapath.
// ---------------------------------------------------------------------------
`default_nettype none
package crr_pkg;

    localparam int unsigned DefMaxReads   = 64;
    localparam int unsigned DefMaxReadLen = 128;
    localparam int unsigned PosW          = 24;
    localparam int unsigned SymW          = 8;
    localparam int unsigned LenW          = 8;
    localparam int unsigned NumW          = 6;

    typedef enum logic [3:0] {
        S_LOAD,
        S_CLEAR,
        S_OUTER,
        S_PAIR,
        S_CMP_ISSUE,
        S_CMP_CHECK,
        S_EMIT
    } t_state;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;        // store the accepted character
        logic clr_set;     // end of run: reset counters
        logic clr_marks;   // clear delete marks
        logic i_init;      // i <= 0, j <= 1
        logic i_next;      // i <= i + 1
        logic j_next;      // j <= j + 1
        logic pair_calc;   // fetch starts and lengths of reads i and j
        logic k_init;      // k <= 0
        logic cmp_rd;      // issue symbol reads for k, then k++
        logic del_inner;   // mark the inner read deleted
        logic emit_init;   // output index <= 0
        logic emit_next;   // output index ++
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic n_zero;      // no reads loaded
        logic i_end;       // i reached count
        logic i_del;       // read i deleted
        logic j_end;       // j reached count
        logic j_del;       // read j deleted
        logic pair_ok;     // spans nest
        logic k_last;      // last character issued
        logic sym_eq;      // registered symbols equal
        logic inner_is_i;  // inner read is read i
        logic emit_last;   // current output is the last
    } t_stat;

endpackage
`default_nettype wire

>>> sv/crr_ctrl.sv
// ---------------------------------------------------------------------------
// crr_ctrl: sequencing controller
// Steps through load, clear, the pairwise pass and result emission.
// ---------------------------------------------------------------------------
`default_nettype none
module crr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_acc,
    input  wire logic          i_set_done,
    input  wire logic          i_out_acc,
    input  wire crr_pkg::t_stat i_stat,
    output crr_pkg::t_cmd       o_cmd,
    output logic               o_in_ready,
    output logic               o_out_valid
);
    import crr_pkg::*;

    t_state r_state, n_state;
    // Compare pipeline: one read in flight whose data lands in the next cycle.
    logic r_last_pend, n_last_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_last_pend <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_last_pend <= n_last_pend;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_last_pend = r_last_pend;
        unique case (r_state)
            S_LOAD: begin
                if (i_in_acc && i_set_done) n_state = S_CLEAR;
            end
            S_CLEAR: n_state = i_stat.n_zero ? S_LOAD : S_OUTER;
            S_OUTER: begin
                if (i_stat.i_end) n_state = S_EMIT;
                else if (i_stat.i_del) n_state = S_OUTER;
                else if (i_stat.j_end) n_state = S_OUTER;
                else if (i_stat.j_del) n_state = S_OUTER;
                else n_state = S_PAIR;
            end
            S_PAIR: begin
                if (!i_stat.pair_ok) n_state = S_OUTER;
                else n_state = S_CMP_ISSUE;
            end
            S_CMP_ISSUE: begin
                n_last_pend = i_stat.k_last;
                n_state     = S_CMP_CHECK;
            end
            S_CMP_CHECK: begin
                if (!i_stat.sym_eq) n_state = S_OUTER;
                else if (r_last_pend) n_state = S_OUTER;
                else n_state = S_CMP_ISSUE;
            end
            S_EMIT: begin
                if (i_out_acc && i_stat.emit_last) n_state = S_LOAD;
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                o_in_ready   = 1'b1;
                o_cmd.load   = i_in_acc;
            end
            S_CLEAR: begin
                o_cmd.clr_marks = 1'b1;
                o_cmd.i_init    = 1'b1;
                o_cmd.emit_init = 1'b1;
                o_cmd.clr_set   = i_stat.n_zero;
            end
            S_OUTER: begin
                if (i_stat.i_end) begin
                    o_cmd.emit_init = 1'b1;
                end else if (i_stat.i_del || i_stat.j_end) begin
                    o_cmd.i_next = 1'b1;
                end else if (i_stat.j_del) begin
                    o_cmd.j_next = 1'b1;
                end else begin
                    o_cmd.pair_calc = 1'b1;
                end
            end
            S_PAIR: begin
                o_cmd.k_init = 1'b1;
                if (!i_stat.pair_ok) o_cmd.j_next = 1'b1;
            end
            S_CMP_ISSUE: o_cmd.cmp_rd = 1'b1;
            S_CMP_CHECK: begin
                if (!i_stat.sym_eq) begin
                    o_cmd.j_next = 1'b1;
                end else if (r_last_pend) begin
                    o_cmd.del_inner = 1'b1;
                    // If i is deleted the inner loop ends.
                    if (i_stat.inner_is_i) o_cmd.i_next = 1'b1;
                    else o_cmd.j_next = 1'b1;
                end
            end
            S_EMIT: begin
                o_out_valid     = 1'b1;
                o_cmd.emit_next = i_out_acc;
                o_cmd.clr_set   = i_out_acc && i_stat.emit_last;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

>>> sv/crr_dp.sv
// ---------------------------------------------------------------------------
// crr_dp: storage and comparison datapath
// Holds read starts, lengths, the symbol memory and delete marks, and the
// loop counters of the pairwise pass.
// ---------------------------------------------------------------------------
`default_nettype none
module crr_dp #(
    parameter int unsigned MaxReads   = crr_pkg::DefMaxReads,
    parameter int unsigned MaxReadLen = crr_pkg::DefMaxReadLen
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire crr_pkg::t_cmd            i_cmd,
    input  wire logic [crr_pkg::PosW-1:0] i_pos,
    input  wire logic [crr_pkg::SymW-1:0] i_sym,
    input  wire logic                     i_read_done,
    input  wire logic                     i_set_done,
    output crr_pkg::t_stat                o_stat,
    output logic [crr_pkg::NumW-1:0]      o_read_number,
    output logic                          o_kept,
    output logic                          o_overflow
);
    import crr_pkg::*;

    localparam int unsigned IdxW = (MaxReads > 1) ? $clog2(MaxReads) : 1;
    localparam int unsigned CntW = $clog2(MaxReads + 1);
    localparam int unsigned KW   = (MaxReadLen > 1) ? $clog2(MaxReadLen) : 1;
    localparam int unsigned AddrW = IdxW + KW;
    localparam int unsigned Depth = MaxReads * (2 ** KW);
    localparam int unsigned SpanW = PosW + 1;

    logic [PosW-1:0] r_starts [MaxReads];
    logic [LenW-1:0] r_lens   [MaxReads];
    logic [SymW-1:0] r_mem    [Depth];
    logic [MaxReads-1:0] r_del;

    logic [CntW-1:0] r_n;
    logic [LenW-1:0] r_sin;
    logic            r_ovf;

    logic [CntW-1:0] r_i, r_j, r_e;
    logic [PosW-1:0] r_pa, r_pb;
    logic [LenW-1:0] r_la, r_lb, r_k;
    logic [SymW-1:0] r_sym_a, r_sym_b;

    // Load side.
    logic            ld_full, ld_long, ld_store, ld_end;
    logic [IdxW-1:0] ld_idx;
    logic [KW-1:0]   ld_k;
    assign ld_full  = (r_n >= CntW'(MaxReads));
    assign ld_long  = (r_sin >= LenW'(MaxReadLen));
    assign ld_store = i_cmd.load && !ld_full && !ld_long;
    assign ld_end   = i_cmd.load && (i_read_done || i_set_done);
    assign ld_idx   = r_n[IdxW-1:0];
    assign ld_k     = r_sin[KW-1:0];

    // Pair geometry from the fetched starts and lengths of reads i and j.
    logic [IdxW-1:0] ia, jb;
    logic [SpanW-1:0] pa, pb, ea1, eb1;
    logic             ovl, a_out;
    assign ia  = r_i[IdxW-1:0];
    assign jb  = r_j[IdxW-1:0];
    assign pa  = SpanW'(r_pa);
    assign pb  = SpanW'(r_pb);
    assign ea1 = pa + SpanW'(r_la);   // one past the end
    assign eb1 = pb + SpanW'(r_lb);
    assign ovl = !(pa >= eb1 || pb >= ea1);
    assign a_out = !(pa > pb || (pa == pb && r_la < r_lb));

    logic [SpanW-1:0] o_end, i_st, i_end1, o_st;
    assign o_st   = a_out ? pa : pb;
    assign o_end  = a_out ? ea1 : eb1;
    assign i_st   = a_out ? pb : pa;
    assign i_end1 = a_out ? eb1 : ea1;

    logic            pair_ok, inner_i;
    logic [IdxW-1:0] outer_idx, inner_idx;
    logic [LenW-1:0] cmp_off, inner_len;
    assign pair_ok   = ovl && (o_end >= i_end1);
    assign outer_idx = a_out ? ia : jb;
    assign inner_idx = a_out ? jb : ia;
    assign inner_i   = !a_out;
    assign cmp_off   = LenW'(i_st - o_st);
    assign inner_len = a_out ? r_lb : r_la;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n   <= '0;
            r_sin <= '0;
            r_ovf <= 1'b0;
            r_del <= '0;
            r_i   <= '0;
            r_j   <= '0;
            r_e   <= '0;
        end else begin
            if (i_cmd.load) begin
                if (ld_full || ld_long) r_ovf <= 1'b1;
                if (ld_end) begin
                    if (!ld_full && (r_sin != '0 || ld_store)) r_n <= r_n + 1'b1;
                    r_sin <= '0;
                end else if (ld_store) begin
                    r_sin <= r_sin + 1'b1;
                end
            end
            if (i_cmd.clr_set) begin
                r_n   <= '0;
                r_sin <= '0;
                r_ovf <= 1'b0;
            end
            if (i_cmd.clr_marks) r_del <= '0;
            if (i_cmd.del_inner) r_del[inner_idx] <= 1'b1;
            if (i_cmd.i_init) begin
                r_i <= '0;
                r_j <= CntW'(1);
            end else if (i_cmd.i_next) begin
                r_i <= r_i + 1'b1;
                r_j <= r_i + CntW'(2);
            end else if (i_cmd.j_next) begin
                r_j <= r_j + 1'b1;
            end
            if (i_cmd.emit_init) r_e <= '0;
            else if (i_cmd.emit_next) r_e <= r_e + 1'b1;
        end
    end

    // Payload registers; starts and lengths are read through registers.
    always_ff @(posedge i_clk) begin
        if (ld_store) begin
            if (r_sin == '0) r_starts[ld_idx] <= i_pos;
            r_lens[ld_idx] <= r_sin + 1'b1;
        end
        if (i_cmd.pair_calc) begin
            r_pa <= r_starts[ia];
            r_pb <= r_starts[jb];
            r_la <= r_lens[ia];
            r_lb <= r_lens[jb];
        end
        if (i_cmd.k_init) r_k <= '0;
        else if (i_cmd.cmp_rd) r_k <= r_k + 1'b1;
    end

    // Symbol memory: one write port, two registered read ports.
    logic [AddrW-1:0] a_addr, b_addr;
    logic [LenW-1:0]  ok_sum;
    assign ok_sum = cmp_off + r_k;
    assign a_addr = {outer_idx, ok_sum[KW-1:0]};
    assign b_addr = {inner_idx, r_k[KW-1:0]};

    always_ff @(posedge i_clk) begin
        if (ld_store) r_mem[{ld_idx, ld_k}] <= i_sym;
        if (i_cmd.cmp_rd) begin
            r_sym_a <= r_mem[a_addr];
            r_sym_b <= r_mem[b_addr];
        end
    end

    always_comb begin
        o_stat            = '0;
        o_stat.n_zero     = (r_n == '0);
        o_stat.i_end      = (r_i >= r_n);
        o_stat.i_del      = r_del[ia];
        o_stat.j_end      = (r_j >= r_n);
        o_stat.j_del      = r_del[jb];
        o_stat.pair_ok    = pair_ok;
        o_stat.k_last     = (r_k + 1'b1 == inner_len);
        o_stat.sym_eq     = (r_sym_a == r_sym_b);
        o_stat.inner_is_i = inner_i;
        o_stat.emit_last  = (r_e + 1'b1 == r_n);
    end

    assign o_read_number = NumW'(r_e);
    assign o_kept        = !r_del[r_e[IdxW-1:0]];
    assign o_overflow    = r_ovf;

endmodule
`default_nettype wire

>>> sv/contained_read_removal.sv
// ---------------------------------------------------------------------------
// contained_read_removal: removes reads contained in other reads
// Loads aligned reads one character per item, then runs a greedy pairwise
// containment pass and emits one keep flag per read.
// ---------------------------------------------------------------------------
//  Channel | Direction | Contents
//  s_axis  | in        | tdata {set_done, read_done, symbol, start_position}
//  m_axis  | out       | tdata {capacity_exceeded, kept, read_number}, tlast last_result
//
// Characters are accepted one per cycle while loading. The item that carries
// set_done starts the pass: each pair passes the outer and pair states, each
// compared character an issue and a check state, bounded by the single symbol
// memory and its two read ports. Results then leave one per cycle, stalling
// with m_axis_tready; no input item is accepted until the last result is taken.
// Reset (synchronous, active low) empties the set; stores need no clearing.
// ---------------------------------------------------------------------------
`default_nettype none
module contained_read_removal #(
    parameter int unsigned MaxReads   = crr_pkg::DefMaxReads,
    parameter int unsigned MaxReadLen = crr_pkg::DefMaxReadLen
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [23:0] start_position, [31:24] symbol, [32] read_done, [33] set_done
    input  wire logic [39:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [5:0] read_number, [6] kept, [7] capacity_exceeded
    output logic [7:0]       m_axis_tdata,
    // last_result
    output logic             m_axis_tlast
);
    import crr_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  in_acc, out_acc;
    logic [NumW-1:0] rd_num;
    logic kept, ovf;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    crr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_acc    (in_acc),
        .i_set_done  (s_axis_tdata[33]),
        .i_out_acc   (out_acc),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid)
    );

    crr_dp #(
        .MaxReads   (MaxReads),
        .MaxReadLen (MaxReadLen)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_pos         (s_axis_tdata[23:0]),
        .i_sym         (s_axis_tdata[31:24]),
        .i_read_done   (s_axis_tdata[32]),
        .i_set_done    (s_axis_tdata[33]),
        .o_stat        (stat),
        .o_read_number (rd_num),
        .o_kept        (kept),
        .o_overflow    (ovf)
    );

    assign m_axis_tdata = {ovf, kept, rd_num};
    assign m_axis_tlast = stat.emit_last;

endmodule
`default_nettype wire

>>> sv/crr_checker.sv
// ---------------------------------------------------------------------------
// crr_checker: port-level checks for contained read removal
// Observes the top-level ports only.
// ---------------------------------------------------------------------------
`default_nettype none
module crr_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       s_axis_tready,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic       m_axis_tlast
);
    // Input and output are never open at once.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("ready during output");

    // Stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");

    // After the last result the block returns to loading.
    a_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
        else $error("not loading after run");

    // Read numbers count up by one.
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
        m_axis_tdata[5:0] == $past(m_axis_tdata[5:0]) + 6'd1)
        else $error("read number skipped");
endmodule

bind contained_read_removal crr_checker u_crr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
